@@ hw/rtl/keyed_list_append_remove_unit_defines.svh @@
// assertion macros for the keyed list checker
`ifndef KEYED_LIST_APPEND_REMOVE_UNIT_DEFINES_SVH
`define KEYED_LIST_APPEND_REMOVE_UNIT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define KLA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kla_pkg.sv @@
package kla_pkg;

    localparam int unsigned TEXT_W   = 64;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned FILL_W   = 7;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [2:0] STS_ADDED     = 3'd0;
    localparam logic [2:0] STS_FULL      = 3'd1;
    localparam logic [2:0] STS_REMOVED   = 3'd2;
    localparam logic [2:0] STS_NOT_FOUND = 3'd3;
    localparam logic [2:0] STS_ENTRY     = 3'd4;
    localparam logic [2:0] STS_EMPTY     = 3'd5;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TEXT_W-1:0] key_text;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic [TEXT_W-1:0]  entry_text;
        logic [INDEX_W-1:0] entry_index;
        logic [FILL_W-1:0]  fill_level;
        logic               last;
    } t_out_word;

    // per-cell control: load the new key, take the head key, or take the neighbor's key
    typedef struct packed {
        logic load;
        logic wrap;
        logic shift;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_READ
    } t_state;

endpackage

@@ hw/rtl/kla_cell.sv @@
module kla_cell #(
    parameter int unsigned KW = 64
) (
    input  logic               i_clk,
    input  kla_pkg::t_cell_ctl i_ctl,
    input  logic [KW-1:0]      i_key,
    input  logic [KW-1:0]      i_next,
    input  logic [KW-1:0]      i_head,
    output logic [KW-1:0]      o_key,
    output logic               o_eq
);
    import kla_pkg::*;

    logic [KW-1:0] r_key;
    logic [KW-1:0] n_key;

    always_comb begin
        priority if (i_ctl.load) begin
            n_key = i_key;
        end else if (i_ctl.wrap) begin
            n_key = i_head;
        end else if (i_ctl.shift) begin
            n_key = i_next;
        end else begin
            n_key = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_eq  = (r_key == i_key);

endmodule

@@ hw/rtl/keyed_list_append_remove_unit.sv @@
// channel | signals                                   | word
// --------+-------------------------------------------+---------------------------
// in      | i_in_valid / o_in_ready / i_in_word       | kind, key_text
// out     | o_out_valid / i_out_ready / o_out_word    | status, entry_text,
//         |                                           | entry_index, fill_level, last
//
// append: the cell at the fill position loads the key
// remove: all cells compare in parallel, then cells at and above the hit shift down
// read: one word per entry per cycle unless stalled, as the held entries rotate through cell 0
// one output register; a new word is taken only once the pending result can leave
// reset clears the fill count and control state; cell contents stay undefined until written
module keyed_list_append_remove_unit #(
    parameter int unsigned CAPACITY  = 64,
    parameter int unsigned KEY_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kla_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kla_pkg::t_out_word o_out_word
);
    import kla_pkg::*;

    localparam int unsigned KW = 8 * KEY_BYTES;
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [CAPACITY-1:0] r_match, n_match;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out_word, n_out_word;

    logic [KW-1:0]       w_key;
    logic [KW-1:0]       cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] w_valid;
    t_cell_ctl           cell_ctl [CAPACITY];

    logic          out_free;
    logic          in_fire;
    logic          full;
    logic          hit;
    logic          read_last;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] hit_pos;
    logic [CAPACITY-1:0] low_bit;
    logic [CAPACITY-1:0] ge_mask;

    // key ends at its first zero byte
    always_comb begin
        logic alive;
        alive = 1'b1;
        w_key = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (i_in_word.key_text[8*b +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                w_key[8*b +: 8] = i_in_word.key_text[8*b +: 8];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KW-1:0] next_key;
        if (g == CAPACITY - 1) begin : g_end
            assign next_key = '0;
        end else begin : g_mid
            assign next_key = cell_key[g+1];
        end

        kla_cell #(.KW(KW)) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl[g]),
            .i_key  (w_key),
            .i_next (next_key),
            .i_head (cell_key[0]),
            .o_key  (cell_key[g]),
            .o_eq   (cell_eq[g])
        );

        assign w_valid[g] = (CW'(g) < r_count);
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign in_fire   = i_in_valid && out_free && (r_state == ST_IDLE);
    assign full      = (r_count == CW'(CAPACITY));
    assign last_idx  = IW'(r_count - CW'(1));
    assign read_last = (r_idx == last_idx);

    // first hit and everything above it
    assign low_bit = r_match & (~r_match + CAPACITY'(1));
    assign ge_mask = ~(low_bit - CAPACITY'(1));
    assign hit     = |r_match;

    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (low_bit[i]) begin
                hit_pos = hit_pos | IW'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_in_word.kind == KIND_REMOVE) begin
                    n_state = ST_REMOVE;
                end else if (in_fire && i_in_word.kind == KIND_READ && r_count != '0) begin
                    n_state = ST_READ;
                end
            end
            ST_REMOVE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free && read_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_in_ready  = 1'b0;
        n_count     = r_count;
        n_idx       = r_idx;
        n_match     = r_match;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctl[i] = '0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
                n_idx      = '0;
                if (in_fire) begin
                    unique case (i_in_word.kind)
                        KIND_APPEND: begin
                            n_out_valid = 1'b1;
                            n_out_word  = '0;
                            n_out_word.last = 1'b1;
                            if (full) begin
                                n_out_word.status     = STS_FULL;
                                n_out_word.fill_level = FILL_W'(r_count);
                            end else begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    cell_ctl[i].load = (r_count == CW'(i));
                                end
                                n_count = r_count + CW'(1);
                                n_out_word.status      = STS_ADDED;
                                n_out_word.entry_index = INDEX_W'(r_count);
                                n_out_word.fill_level  = FILL_W'(r_count + CW'(1));
                            end
                        end
                        KIND_REMOVE: begin
                            n_match = cell_eq & w_valid;
                        end
                        KIND_READ: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out_word  = '0;
                                n_out_word.status = STS_EMPTY;
                                n_out_word.last   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_REMOVE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '0;
                    n_out_word.last = 1'b1;
                    if (hit) begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            cell_ctl[i].shift = ge_mask[i];
                        end
                        n_count = r_count - CW'(1);
                        n_out_word.status      = STS_REMOVED;
                        n_out_word.entry_index = INDEX_W'(hit_pos);
                        n_out_word.fill_level  = FILL_W'(r_count - CW'(1));
                    end else begin
                        n_out_word.status     = STS_NOT_FOUND;
                        n_out_word.fill_level = FILL_W'(r_count);
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    // rotate the held entries; the last held cell takes the head
                    for (int i = 0; i < CAPACITY; i++) begin
                        cell_ctl[i].shift = w_valid[i];
                        cell_ctl[i].wrap  = (last_idx == IW'(i));
                    end
                    n_idx       = r_idx + IW'(1);
                    n_out_valid = 1'b1;
                    n_out_word.status      = STS_ENTRY;
                    n_out_word.entry_text  = TEXT_W'(cell_key[0]);
                    n_out_word.entry_index = INDEX_W'(r_idx);
                    n_out_word.fill_level  = FILL_W'(r_count);
                    n_out_word.last        = read_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match    <= n_match;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ hw/rtl/kla_checker.sv @@
`include "keyed_list_append_remove_unit_defines.svh"

module kla_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input kla_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input kla_pkg::t_out_word o_out_word
);
    import kla_pkg::*;

    // a stalled result word holds
    `KLA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "result word changed while stalled")

    `KLA_ASSERT_NOW(a_fill_cap, o_out_valid, o_out_word.fill_level <= CAPACITY, "fill level above capacity")

    // a read-out in progress blocks new words
    `KLA_ASSERT_NOW(a_run_blocks, o_out_valid && !o_out_word.last, !o_in_ready, "input taken during read-out")

    `KLA_ASSERT_NOW(a_text_zero, o_out_valid && o_out_word.status != STS_ENTRY, o_out_word.entry_text == '0, "text on non-entry result")

    `KLA_ASSERT_NOW(a_entry_index, o_out_valid && o_out_word.status == STS_ENTRY, o_out_word.entry_index < o_out_word.fill_level, "entry index beyond fill level")

endmodule

bind keyed_list_append_remove_unit kla_checker #(.CAPACITY(CAPACITY)) u_kla_checker (.*);
